/* design/gfib_pkg.sv */
// shared constants, types and helpers for the generalized fibonacci block
package gfib_pkg;

  localparam int RES_W = 30;
  localparam int INDEX_WIDTH_DEF = 32;

  // the prime and its barrett constant floor(2^60 / p)
  localparam logic [RES_W-1:0] PRIME = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_CROSS,
    ST_WAIT,
    ST_STEP,
    ST_FIN_S0,
    ST_FIN_S1,
    ST_FIN_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AA,
    MUL_BB,
    MUL_AT,
    MUL_S0,
    MUL_S1
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t mul_op;
    logic    step;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic last_bit;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] x,
                                                input logic [RES_W-1:0] y);
    logic [RES_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[RES_W-1:0];
  endfunction

  function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] x,
                                                input logic [RES_W-1:0] y);
    logic [RES_W:0] s;
    s = {1'b0, x} - {1'b0, y};
    if (x < y) begin
      s = s + {1'b0, PRIME};
    end
    return s[RES_W-1:0];
  endfunction

endpackage

/* design/gfib_in_if.sv */
// request channel of the generalized fibonacci block
interface gfib_in_if #(
  parameter int INDEX_WIDTH = gfib_pkg::INDEX_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [gfib_pkg::RES_W-1:0] seed_first;
  logic [gfib_pkg::RES_W-1:0] seed_second;
  logic [INDEX_WIDTH-1:0]     term_index;

  modport source (output valid, seed_first, seed_second, term_index, input ready);
  modport sink (input valid, seed_first, seed_second, term_index, output ready);
endinterface

/* design/gfib_out_if.sv */
// result channel of the generalized fibonacci block
interface gfib_out_if;
  logic                       valid;
  logic                       ready;
  logic [gfib_pkg::RES_W-1:0] term_value;

  modport source (output valid, term_value, input ready);
  modport sink (input valid, term_value, output ready);
endinterface

/* design/gfib_mulmod.sv */
// five stage pipelined modular multiplier, barrett reduction by the prime
module gfib_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gfib_pkg::mul_op_t          op_in,
  input  logic [gfib_pkg::RES_W-1:0] x,
  input  logic [gfib_pkg::RES_W-1:0] y,
  output logic                       res_valid,
  output gfib_pkg::mul_op_t          res_op,
  output logic [gfib_pkg::RES_W-1:0] res,
  output logic                       busy
);

  localparam int STAGES = 5;

  logic [STAGES-1:0]      vld_r;
  gfib_pkg::mul_op_t      op_r [STAGES];

  logic [59:0]            prod_r;
  logic [61:0]            q2_r;
  logic [31:0]            lo2_r;
  logic [31:0]            lo3_r;
  logic [31:0]            qp_r;
  logic [31:0]            rem_r;
  logic [gfib_pkg::RES_W-1:0] res_r;

  logic [30:0]            q3;
  logic [60:0]            qp_full;
  logic [31:0]            red;

  assign q3      = q2_r[61:31];
  assign qp_full = 61'(q3) * 61'(gfib_pkg::PRIME);

  // remainder below three times the prime
  always_comb begin
    if (rem_r >= 32'(2 * 64'(gfib_pkg::PRIME))) begin
      red = rem_r - 32'(2 * 64'(gfib_pkg::PRIME));
    end else if (rem_r >= 32'(gfib_pkg::PRIME)) begin
      red = rem_r - 32'(gfib_pkg::PRIME);
    end else begin
      red = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], op_in != gfib_pkg::MUL_NONE};
    end
  end

  always_ff @(posedge clk) begin
    op_r[0] <= op_in;
    for (int i = 1; i < STAGES; i++) begin
      op_r[i] <= op_r[i-1];
    end
    prod_r <= 60'(x) * 60'(y);
    q2_r   <= 62'(prod_r[59:29]) * 62'(gfib_pkg::BARRETT_MU);
    lo2_r  <= prod_r[31:0];
    lo3_r  <= lo2_r;
    qp_r   <= qp_full[31:0];
    rem_r  <= lo3_r - qp_r;
    res_r  <= red[gfib_pkg::RES_W-1:0];
  end

  assign res_valid = vld_r[STAGES-1];
  assign res_op    = op_r[STAGES-1];
  assign res       = res_r;
  assign busy      = |vld_r;

endmodule

/* design/gfib_datapath.sv */
// operand registers, fast doubling update and result register
module gfib_datapath #(
  parameter int INDEX_WIDTH = gfib_pkg::INDEX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gfib_pkg::dp_cmd_t          cmd,
  output gfib_pkg::dp_stat_t         stat,
  input  logic [gfib_pkg::RES_W-1:0] seed_first,
  input  logic [gfib_pkg::RES_W-1:0] seed_second,
  input  logic [INDEX_WIDTH-1:0]     term_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gfib_pkg::RES_W-1:0] term_value
);

  localparam int CNT_W = (INDEX_WIDTH > 1) ? $clog2(INDEX_WIDTH) : 1;
  localparam int W = gfib_pkg::RES_W;

  logic [W-1:0]           s0_r, s1_r;
  logic [INDEX_WIDTH-1:0] idx_r;
  logic [CNT_W-1:0]       cnt_r;
  // a = F(k), b = F(k+1)
  logic [W-1:0]           a_r, b_r;
  logic [W-1:0]           p0_r, p1_r, p2_r;
  logic                   out_valid_r;
  logic [W-1:0]           out_value_r;

  logic [W-1:0]           mx, my;
  logic [W+1:0]           t_raw;
  logic [W-1:0]           t_mod;
  logic [W-1:0]           c_val, d_val;
  logic                   res_valid;
  gfib_pkg::mul_op_t      res_op;
  logic [W-1:0]           res;
  logic                   mul_busy;

  function automatic logic [W-1:0] reduce_seed(input logic [W-1:0] v);
    return (v >= gfib_pkg::PRIME) ? v - gfib_pkg::PRIME : v;
  endfunction

  // 2b - a mod p, via 2b + p - a below three p
  always_comb begin
    t_raw = {1'b0, b_r, 1'b0} + (W+2)'(gfib_pkg::PRIME) - (W+2)'(a_r);
    if (t_raw >= (W+2)'(2 * 64'(gfib_pkg::PRIME))) begin
      t_mod = W'(t_raw - (W+2)'(2 * 64'(gfib_pkg::PRIME)));
    end else if (t_raw >= (W+2)'(gfib_pkg::PRIME)) begin
      t_mod = W'(t_raw - (W+2)'(gfib_pkg::PRIME));
    end else begin
      t_mod = t_raw[W-1:0];
    end
  end

  always_comb begin
    unique case (cmd.mul_op)
      gfib_pkg::MUL_AA: begin mx = a_r;  my = a_r; end
      gfib_pkg::MUL_BB: begin mx = b_r;  my = b_r; end
      gfib_pkg::MUL_AT: begin mx = a_r;  my = t_mod; end
      gfib_pkg::MUL_S0: begin mx = s0_r; my = gfib_pkg::mod_sub(b_r, a_r); end
      gfib_pkg::MUL_S1: begin mx = s1_r; my = a_r; end
      default:          begin mx = '0;   my = '0; end
    endcase
  end

  gfib_mulmod u_mulmod (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_in     (cmd.mul_op),
    .x         (mx),
    .y         (my),
    .res_valid (res_valid),
    .res_op    (res_op),
    .res       (res),
    .busy      (mul_busy)
  );

  // F(2k) and F(2k+1)
  assign c_val = p2_r;
  assign d_val = gfib_pkg::mod_add(p0_r, p1_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s0_r  <= reduce_seed(seed_first);
      s1_r  <= reduce_seed(seed_second);
      idx_r <= term_index;
      cnt_r <= CNT_W'(INDEX_WIDTH - 1);
      a_r   <= '0;
      b_r   <= W'(1);
    end else if (cmd.step) begin
      idx_r <= idx_r << 1;
      cnt_r <= cnt_r - CNT_W'(1);
      if (idx_r[INDEX_WIDTH-1]) begin
        a_r <= d_val;
        b_r <= gfib_pkg::mod_add(c_val, d_val);
      end else begin
        a_r <= c_val;
        b_r <= d_val;
      end
    end
    if (res_valid) begin
      unique case (res_op)
        gfib_pkg::MUL_AA, gfib_pkg::MUL_S0: p0_r <= res;
        gfib_pkg::MUL_BB, gfib_pkg::MUL_S1: p1_r <= res;
        gfib_pkg::MUL_AT:                   p2_r <= res;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_value_r <= gfib_pkg::mod_add(p0_r, p1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.mul_busy = mul_busy;
  assign stat.last_bit = (cnt_r == '0);
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign term_value = out_value_r;

endmodule

/* design/gfib_ctrl.sv */
// controller that sequences the products of each doubling step and the two final products
module gfib_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gfib_pkg::dp_stat_t stat,
  output gfib_pkg::dp_cmd_t  cmd
);

  gfib_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gfib_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gfib_pkg::ST_IDLE:     if (in_valid) state_nxt = gfib_pkg::ST_SQ_A;
      gfib_pkg::ST_SQ_A:     state_nxt = gfib_pkg::ST_SQ_B;
      gfib_pkg::ST_SQ_B:     state_nxt = gfib_pkg::ST_CROSS;
      gfib_pkg::ST_CROSS:    state_nxt = gfib_pkg::ST_WAIT;
      gfib_pkg::ST_WAIT:     if (!stat.mul_busy) state_nxt = gfib_pkg::ST_STEP;
      gfib_pkg::ST_STEP:     state_nxt = stat.last_bit ? gfib_pkg::ST_FIN_S0
                                                       : gfib_pkg::ST_SQ_A;
      gfib_pkg::ST_FIN_S0:   state_nxt = gfib_pkg::ST_FIN_S1;
      gfib_pkg::ST_FIN_S1:   state_nxt = gfib_pkg::ST_FIN_WAIT;
      gfib_pkg::ST_FIN_WAIT: if (!stat.mul_busy) state_nxt = gfib_pkg::ST_EMIT;
      gfib_pkg::ST_EMIT:     if (!stat.out_busy) state_nxt = gfib_pkg::ST_IDLE;
      default:               state_nxt = gfib_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == gfib_pkg::ST_IDLE);
    cmd.load   = (state_r == gfib_pkg::ST_IDLE) && in_valid;
    cmd.step   = (state_r == gfib_pkg::ST_STEP);
    cmd.emit   = (state_r == gfib_pkg::ST_EMIT) && !stat.out_busy;
    unique case (state_r)
      gfib_pkg::ST_SQ_A:   cmd.mul_op = gfib_pkg::MUL_AA;
      gfib_pkg::ST_SQ_B:   cmd.mul_op = gfib_pkg::MUL_BB;
      gfib_pkg::ST_CROSS:  cmd.mul_op = gfib_pkg::MUL_AT;
      gfib_pkg::ST_FIN_S0: cmd.mul_op = gfib_pkg::MUL_S0;
      gfib_pkg::ST_FIN_S1: cmd.mul_op = gfib_pkg::MUL_S1;
      default:             cmd.mul_op = gfib_pkg::MUL_NONE;
    endcase
  end

endmodule

/* design/generalized_fibonacci_mod_prime.sv */
// top level of the generalized fibonacci term modulo 1000000007
//
// Each request carries two seeds and an index n; the block returns term n of the
// sequence that starts with the seeds and adds the two previous terms, modulo
// 1000000007, that is seed_first*F(n-1) + seed_second*F(n). Seeds at or above
// the prime are reduced first; only the low INDEX_WIDTH bits of the index count.
// The work runs by fast doubling over the index bits, most significant first:
// from (F(k), F(k+1)) three modular products give F(2k) and F(2k+1), and the
// bit picks the next pair. Two final products form the answer. All products go
// through one shared five stage modular multiplier (30x30 product, then a
// barrett reduction by the prime), and a step waits for that pipe to drain
// before the pair is updated. The run time of a request does not depend on the
// index value. One request is worked on at a time. The result sits in an output
// register, so a new request is taken while the previous result waits.
module generalized_fibonacci_mod_prime #(
  parameter int INDEX_WIDTH = gfib_pkg::INDEX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gfib_in_if.sink   in_chan,
  gfib_out_if.source out_chan
);

  gfib_pkg::dp_cmd_t  cmd;
  gfib_pkg::dp_stat_t stat;

  // sequencer: issues products, waits for the pipe, steps the pair
  gfib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // operand registers, shared multiplier and result register
  gfib_datapath #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .seed_first  (in_chan.seed_first),
    .seed_second (in_chan.seed_second),
    .term_index  (in_chan.term_index),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .term_value  (out_chan.term_value)
  );

  // a result is always a residue
  a_value_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.term_value < gfib_pkg::PRIME))
    else $error("term value not reduced");

  // a new request only starts with the multiplier pipe empty
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> !stat.mul_busy)
    else $error("multiplier busy while idle");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("ready right after a request");

  // a result is never loaded over one that waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !cmd.emit)
    else $error("result overwritten");

endmodule

/* tb/generalized_fibonacci_mod_prime_tb.sv */
// testbench for the generalized fibonacci term modulo 1000000007
`timescale 1ns / 100ps

module generalized_fibonacci_mod_prime_tb;

  localparam int INDEX_W = gfib_pkg::INDEX_WIDTH_DEF;
  localparam int RES_W = gfib_pkg::RES_W;
  localparam logic [RES_W-1:0] PRIME = gfib_pkg::PRIME;
  localparam int RANDOM_REQS = 1200;
  localparam int TAIL_CYCLES = 400;    // a bit more than one request's latency

  // one pending request plus the idle cycles the driver inserts after it
  typedef struct {
    logic [RES_W-1:0]   seed_first;
    logic [RES_W-1:0]   seed_second;
    logic [INDEX_W-1:0] term_index;
    int                 gap_after;
  } fib_req_t;

  logic clk;
  logic rst_n;

  gfib_in_if #(.INDEX_WIDTH(INDEX_W)) in_bus ();
  gfib_out_if out_bus ();

  generalized_fibonacci_mod_prime #(.INDEX_WIDTH(INDEX_W)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  fib_req_t         pending_reqs[$];
  logic [RES_W-1:0] expected_terms[$];
  int               reqs_total = 0;
  int               reqs_accepted = 0;
  int               terms_seen = 0;
  int               mismatch_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // term n of t(0)=seed_first, t(1)=seed_second, t(k)=t(k-1)+t(k-2) mod p:
  // raise [[0,1],[1,1]] to the n-th power, msb first, then
  // t(n) = seed_first*F(n-1) + seed_second*F(n) from the top row
  function automatic logic [RES_W-1:0] fib_term_mod_p(input logic [RES_W-1:0] seed_first,
                                                       input logic [RES_W-1:0] seed_second,
                                                       input logic [INDEX_W-1:0] term_index);
    longint unsigned p, s0, s1;
    longint unsigned a00, a01, a10, a11;
    longint unsigned n00, n01, n10, n11;
    p = 64'(PRIME);
    // seeds at or above the prime fold back with one subtraction
    s0 = 64'(seed_first);
    s1 = 64'(seed_second);
    if (s0 >= p) s0 = s0 - p;
    if (s1 >= p) s1 = s1 - p;
    a00 = 64'd1;
    a01 = 64'd0;
    a10 = 64'd0;
    a11 = 64'd1;
    for (int b = INDEX_W - 1; b >= 0; b--) begin
      // square; each product is below 2^60 so two of them fit in 64 bits
      n00 = (a00 * a00 + a01 * a10) % p;
      n01 = (a00 * a01 + a01 * a11) % p;
      n10 = (a10 * a00 + a11 * a10) % p;
      n11 = (a10 * a01 + a11 * a11) % p;
      a00 = n00;
      a01 = n01;
      a10 = n10;
      a11 = n11;
      if (term_index[b]) begin
        // times [[0,1],[1,1]]: columns shift and the right one sums
        n00 = a01;
        n01 = (a00 + a01) % p;
        n10 = a11;
        n11 = (a10 + a11) % p;
        a00 = n00;
        a01 = n01;
        a10 = n10;
        a11 = n11;
      end
    end
    return RES_W'((s0 * a00 % p + s1 * a01 % p) % p);
  endfunction

  task automatic add_req(input logic [RES_W-1:0] seed_first,
                         input logic [RES_W-1:0] seed_second,
                         input logic [INDEX_W-1:0] term_index,
                         input int gap_after);
    fib_req_t req;
    req.seed_first = seed_first;
    req.seed_second = seed_second;
    req.term_index = term_index;
    req.gap_after = gap_after;
    pending_reqs.insert(pending_reqs.size(), req);
  endtask

  // random seed: mostly proper residues, some at the edges, some above the prime
  function automatic logic [RES_W-1:0] rand_seed();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return PRIME - RES_W'(1);
    if (pick < 4) return RES_W'($urandom_range(int'(PRIME), (1 << RES_W) - 1));
    return RES_W'($urandom_range(0, int'(PRIME) - 1));
  endfunction

  // random index: small ones, full width ones, and everything in between
  function automatic logic [INDEX_W-1:0] rand_index();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return INDEX_W'($urandom_range(0, 100));
    if (pick == 1) return INDEX_W'($urandom);
    return INDEX_W'($urandom >> $urandom_range(0, 31));
  endfunction

  // stimulus: directed corners first, then random requests
  initial begin
    logic [INDEX_W-1:0] all_ones;
    int gap;
    all_ones = '1;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.seed_first = '0;
    in_bus.seed_second = '0;
    in_bus.term_index = '0;
    out_bus.ready = 1'b0;

    // index zero and one hand back the seeds, small indices walk the sequence
    add_req(RES_W'(0), RES_W'(0), INDEX_W'(0), 0);
    add_req(RES_W'(5), RES_W'(7), INDEX_W'(0), 1);
    add_req(RES_W'(5), RES_W'(7), INDEX_W'(1), 0);
    add_req(RES_W'(5), RES_W'(7), INDEX_W'(2), 3);
    add_req(RES_W'(0), RES_W'(1), INDEX_W'(10), 0);
    add_req(PRIME - RES_W'(1), PRIME - RES_W'(1), INDEX_W'(3), 2);
    // seeds at or above the prime are folded before use
    add_req(PRIME, PRIME + RES_W'(5), INDEX_W'(0), 0);
    add_req(PRIME, '1, INDEX_W'(1), 0);
    add_req('1, '1, INDEX_W'(2), 1);
    add_req('1, PRIME, INDEX_W'(5), 0);
    // widest indices, alternating bit patterns on all fields
    add_req(RES_W'(1), RES_W'(0), all_ones, 0);
    add_req(RES_W'(0), RES_W'(1), all_ones, 2);
    add_req(PRIME - RES_W'(1), RES_W'(1), {1'b1, {(INDEX_W - 1){1'b0}}}, 0);
    add_req(30'h2aaaaaaa, 30'h15555555, {(INDEX_W / 2){2'b01}}, 0);
    add_req(30'h15555555, 30'h2aaaaaaa, {(INDEX_W / 2){2'b10}}, 3);
    add_req(RES_W'(1), RES_W'(1), all_ones >> 1, 0);
    add_req(RES_W'(123456789), RES_W'(987654321), INDEX_W'(1000000006), 1);
    add_req(PRIME - RES_W'(1), RES_W'(0), INDEX_W'(1000000007), 0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      // every few hundred requests a stretch with back to back traffic
      gap = ((i % 200) < 40) ? 0 : $urandom_range(0, 3);
      add_req(rand_seed(), rand_seed(), rand_index(), gap);
    end
    reqs_total = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted != reqs_total) @(posedge clk);
    while (expected_terms.size() != 0) @(posedge clk);
    // stray results after the last expected one still get flagged
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("generalized_fibonacci_mod_prime_tb: done, clean");
    end else begin
      $display("generalized_fibonacci_mod_prime_tb: done, errors");
    end
    $finish;
  end

  // request driver: holds the payload until taken, then leaves valid low for the gap the request asks for
  always @(posedge clk) begin : req_driver
    fib_req_t req;
    int       gap_left;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        // accepted at this edge, so predict now
        expected_terms.insert(expected_terms.size(),
                              fib_term_mod_p(in_bus.seed_first, in_bus.seed_second,
                                             in_bus.term_index));
        reqs_accepted++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          req = pending_reqs.pop_front();
          in_bus.seed_first <= req.seed_first;
          in_bus.seed_second <= req.seed_second;
          in_bus.term_index <= req.term_index;
          in_bus.valid <= 1'b1;
          gap_left = req.gap_after;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each result, then may hold ready low to stall the next one
  always @(posedge clk) begin : term_monitor
    logic [RES_W-1:0] want;
    int               stall_left;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_terms.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d",
                   $time, out_bus.term_value);
          mismatch_count++;
        end else begin
          want = expected_terms.pop_front();
          if (out_bus.term_value !== want) begin
            $display("%0t: term_value mismatch, expected %0d, actual %0d",
                     $time, want, out_bus.term_value);
            mismatch_count++;
          end
        end
        terms_seen++;
        // stretches without stalls alternate with random back pressure
        stall_left = ((terms_seen % 150) < 30) ? 0 : $urandom_range(0, 3);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_bus.ready <= (stall_left == 0);
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("generalized_fibonacci_mod_prime_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
design/gfib_pkg.sv
design/gfib_in_if.sv
design/gfib_out_if.sv
design/gfib_mulmod.sv
design/gfib_datapath.sv
design/gfib_ctrl.sv
design/generalized_fibonacci_mod_prime.sv
tb/generalized_fibonacci_mod_prime_tb.sv
